### src/ccsc_pkg.sv
// ----------------------------------------------------------------------------
// ccsc_pkg: shared types and constants for connector state control
// Command codes, register indexes, connector states and the transaction,
// context and result structures used across the block.
// ----------------------------------------------------------------------------
package ccsc_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_CHECK_INTERVAL   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FINISH_TIMEOUT   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRESENCE_DEBOUNCE = 2'd2;

   localparam logic [15:0] CHECK_INTERVAL_RST    = 16'd500;
   localparam logic [31:0] FINISH_TIMEOUT_RST    = 32'd30000;
   localparam logic [15:0] PRESENCE_DEBOUNCE_RST = 16'd1000;

   typedef enum logic [2:0] {
      CMD_POLL         = 3'd0,
      CMD_TXN_STARTED  = 3'd1,
      CMD_TXN_STOPPED  = 3'd2,
      CMD_REMOTE_START = 3'd3,
      CMD_REMOTE_STOP  = 3'd4
   } cmd_type;

   typedef enum logic [8:0] {
      ST_AVAILABLE   = 9'b000000001,
      ST_PREPARING   = 9'b000000010,
      ST_CHARGING    = 9'b000000100,
      ST_SUSP_EVSE   = 9'b000001000,
      ST_SUSP_EV     = 9'b000010000,
      ST_FINISHING   = 9'b000100000,
      ST_RESERVED    = 9'b001000000,
      ST_UNAVAILABLE = 9'b010000000,
      ST_FAULTED     = 9'b100000000
   } conn_state_type;

   typedef struct packed {
      logic [15:0] check_interval_ms;
      logic [31:0] finish_limit_ms;
      logic [15:0] presence_debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [31:0]        now_ms;
      logic               module_healthy;
      logic               battery_connected;
      logic               gun_connected;
      logic               bms_safe;
      logic               hw_fault;
      logic signed [31:0] txn_id;
   } item_type;

   typedef struct packed {
      conn_state_type conn_state;
      logic [31:0]    state_entry_time;
      logic           seen_battery;
      logic           seen_plug;
      logic [31:0]    battery_check_time;
      logic [31:0]    plug_check_time;
      logic           raw_presence_last;
      logic [31:0]    raw_change_time;
      logic           vehicle_present;
   } ctx_type;

   typedef struct packed {
      logic [3:0] conn_state;
      logic       accepted;
      logic       persist_txn;
      logic       clear_txn;
      logic       txn_start_note;
      logic       txn_end_note;
      logic       bms_alert;
   } result_type;

   // one-hot state to the external 0..8 code
   function automatic logic [3:0] state_code(input conn_state_type s);
      logic [3:0] code;
      code = 4'd0;
      unique case (s)
         ST_AVAILABLE:   code = 4'd0;
         ST_PREPARING:   code = 4'd1;
         ST_CHARGING:    code = 4'd2;
         ST_SUSP_EVSE:   code = 4'd3;
         ST_SUSP_EV:     code = 4'd4;
         ST_FINISHING:   code = 4'd5;
         ST_RESERVED:    code = 4'd6;
         ST_UNAVAILABLE: code = 4'd7;
         ST_FAULTED:     code = 4'd8;
         default:        code = 4'd0;
      endcase
      return code;
   endfunction

endpackage

### src/ccsc_cfg.sv
// ----------------------------------------------------------------------------
// ccsc_cfg: configuration registers
// Decodes the write port into the check interval, finishing timeout and
// presence debounce registers. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ccsc_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ccsc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ccsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output ccsc_pkg::cfg_type               cfg
);
   import ccsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_CHECK_INTERVAL:    cfg_in.check_interval_ms    = csr_wdata[15:0];
            CSR_FINISH_TIMEOUT:    cfg_in.finish_limit_ms      = csr_wdata;
            CSR_PRESENCE_DEBOUNCE: cfg_in.presence_debounce_ms = csr_wdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_interval_ms    <= CHECK_INTERVAL_RST;
         cfg_ff.finish_limit_ms      <= FINISH_TIMEOUT_RST;
         cfg_ff.presence_debounce_ms <= PRESENCE_DEBOUNCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/ccsc_step.sv
// ----------------------------------------------------------------------------
// ccsc_step: per-transaction next-state logic
// Computes the connector context after one command and the result fields.
// Presence is debounced once per transaction; the sampled value is committed
// only when some path of the command consults it.
// ----------------------------------------------------------------------------
module ccsc_step (
   input  ccsc_pkg::item_type   item,
   input  ccsc_pkg::ctx_type    ctx,
   input  ccsc_pkg::cfg_type    cfg,
   output ccsc_pkg::ctx_type    ctx_next,
   output ccsc_pkg::result_type result
);
   import ccsc_pkg::*;

   ctx_type        nxt;
   result_type     res;
   conn_state_type st;
   logic           raw;
   logic [31:0]    rct_s;
   logic           pres;
   logic           sampled;
   logic           rearm;
   logic           batt_due;
   logic           plug_due;
   logic           fin_due;
   logic           batt;
   logic [31:0]    now;

   always_comb begin
      nxt     = ctx;
      res     = '0;
      st      = ctx.conn_state;
      now     = item.now_ms;
      batt    = item.battery_connected;
      raw     = item.gun_connected | item.battery_connected;
      sampled = 1'b0;
      rearm   = 1'b0;

      rct_s = (raw != ctx.raw_presence_last) ? now : ctx.raw_change_time;
      pres  = ((raw != ctx.vehicle_present) &&
               ((now - rct_s) > {16'd0, cfg.presence_debounce_ms})) ? raw
                                                                   : ctx.vehicle_present;

      batt_due = (now - ctx.battery_check_time) > {16'd0, cfg.check_interval_ms};
      plug_due = (now - ctx.plug_check_time) > {16'd0, cfg.check_interval_ms};
      fin_due  = (now - ctx.state_entry_time) > cfg.finish_limit_ms;

      unique case (item.cmd)
         CMD_POLL: begin
            if (!item.module_healthy) begin
               st = ST_FAULTED;
            end else begin
               if (st == ST_FAULTED) begin
                  // recovery forces both change checks to re-evaluate
                  st               = ST_AVAILABLE;
                  nxt.seen_battery = !batt;
                  nxt.seen_plug    = !pres;
                  sampled          = 1'b1;
               end
               if (batt_due) begin
                  nxt.battery_check_time = now;
                  if (batt != nxt.seen_battery) begin
                     nxt.seen_battery = batt;
                     if (batt) begin
                        if (st == ST_AVAILABLE) st = ST_PREPARING;
                     end else if (st != ST_AVAILABLE && st != ST_FAULTED) begin
                        sampled = 1'b1;
                        if (!pres) begin
                           if (st == ST_CHARGING || st == ST_PREPARING) begin
                              res.clear_txn    = 1'b1;
                              res.txn_end_note = 1'b1;
                           end
                           st = ST_AVAILABLE;
                        end
                     end
                  end
               end
               if (plug_due) begin
                  nxt.plug_check_time = now;
                  sampled             = 1'b1;
                  if (pres != nxt.seen_plug) begin
                     nxt.seen_plug = pres;
                     if (!pres && st == ST_FINISHING && !batt) begin
                        st               = ST_AVAILABLE;
                        res.clear_txn    = 1'b1;
                        res.txn_end_note = 1'b1;
                     end
                  end
               end
               // only reachable with the state unchanged in this transaction
               if (st == ST_FINISHING && fin_due) begin
                  sampled = 1'b1;
                  if (!pres && !batt) begin
                     st               = ST_AVAILABLE;
                     res.clear_txn    = 1'b1;
                     res.txn_end_note = 1'b1;
                  end else begin
                     rearm = 1'b1;
                  end
               end
            end
         end
         CMD_TXN_STARTED: begin
            res.persist_txn = !item.txn_id[31] && (item.txn_id != 32'sd0);
            if (st != ST_CHARGING) begin
               st                 = ST_CHARGING;
               res.txn_start_note = 1'b1;
            end
         end
         CMD_TXN_STOPPED: begin
            sampled          = 1'b1;
            st               = (pres || batt) ? ST_FINISHING : ST_AVAILABLE;
            res.clear_txn    = 1'b1;
            res.txn_end_note = 1'b1;
         end
         CMD_REMOTE_START: begin
            res.accepted  = item.module_healthy && item.bms_safe && !item.hw_fault &&
                            item.gun_connected;
            res.bms_alert = item.module_healthy && !item.bms_safe;
         end
         CMD_REMOTE_STOP: begin
            if (st == ST_CHARGING || st == ST_PREPARING || st == ST_SUSP_EV ||
                st == ST_SUSP_EVSE || st == ST_FINISHING) begin
               st           = ST_FINISHING;
               res.accepted = 1'b1;
            end
         end
         default: begin
            st = ctx.conn_state;
         end
      endcase

      if (sampled) begin
         nxt.raw_presence_last = raw;
         nxt.raw_change_time   = rct_s;
         nxt.vehicle_present   = pres;
      end

      nxt.conn_state = st;
      if (st != ctx.conn_state || rearm) nxt.state_entry_time = now;

      res.conn_state = state_code(st);
   end

   assign ctx_next = nxt;
   assign result   = res;

endmodule

### src/charger_connector_state_control_top.sv
// ----------------------------------------------------------------------------
// charger_connector_state_control_top: connector state control, top level
// Path: an accepted request is held in the input register, then stepped into
// the result register. Throughput: one transaction per cycle while rsp_ready
// is high; the connector context updates once per transaction.
// Reset: synchronous; state Available, context zero, valids clear, cfg defaults.
// ----------------------------------------------------------------------------
module charger_connector_state_control_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ccsc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ccsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_cmd,
   input  logic [31:0]                     req_now_ms,
   input  logic                            req_module_healthy,
   input  logic                            req_battery_connected,
   input  logic                            req_gun_connected,
   input  logic                            req_bms_safe,
   input  logic                            req_hw_fault,
   input  logic signed [31:0]              req_txn_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3:0]                      rsp_conn_state,
   output logic                            rsp_accepted,
   output logic                            rsp_persist_txn,
   output logic                            rsp_clear_txn,
   output logic                            rsp_txn_start_note,
   output logic                            rsp_txn_end_note,
   output logic                            rsp_bms_alert
);
   import ccsc_pkg::*;

   cfg_type    cfg;
   item_type   in_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   result_type out_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   ctx_type    ctx_ff;
   ctx_type    ctx_in;
   result_type step_res;
   logic       advance;
   logic       req_fire;

   ccsc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ccsc_step u_step (
      .item     (in_ff),
      .ctx      (ctx_ff),
      .cfg      (cfg),
      .ctx_next (ctx_in),
      .result   (step_res)
   );

   // the held transaction moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctx_ff       <= '{conn_state: ST_AVAILABLE, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) ctx_ff <= ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff.cmd               <= req_cmd;
         in_ff.now_ms            <= req_now_ms;
         in_ff.module_healthy    <= req_module_healthy;
         in_ff.battery_connected <= req_battery_connected;
         in_ff.gun_connected     <= req_gun_connected;
         in_ff.bms_safe          <= req_bms_safe;
         in_ff.hw_fault          <= req_hw_fault;
         in_ff.txn_id            <= req_txn_id;
      end
      if (advance) out_ff <= step_res;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_conn_state     = out_ff.conn_state;
   assign rsp_accepted       = out_ff.accepted;
   assign rsp_persist_txn    = out_ff.persist_txn;
   assign rsp_clear_txn      = out_ff.clear_txn;
   assign rsp_txn_start_note = out_ff.txn_start_note;
   assign rsp_txn_end_note   = out_ff.txn_end_note;
   assign rsp_bms_alert      = out_ff.bms_alert;

`ifndef SYNTH
   a_held_not_lost: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("held transaction dropped without advancing");

   a_unhealthy_poll_faults: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.cmd == CMD_POLL && !in_ff.module_healthy
      |=> ctx_ff.conn_state == ST_FAULTED)
      else $error("unhealthy poll did not enter Faulted");

   a_clear_with_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.clear_txn |-> out_ff.txn_end_note)
      else $error("clear pulse without end notification");

   a_accept_alert_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.accepted && out_ff.bms_alert))
      else $error("remote start both accepted and refused");

   a_result_matches_ctx: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_ff.conn_state == state_code(ctx_ff.conn_state))
      else $error("reported state differs from stored state");
`endif

endmodule
